// File: src/cyclic_code_encode_correct_core_macros.svh
// Assertion helpers for the cyclic code core. Each expects clk and rst_n in scope.
`ifndef CYCLIC_CODE_ENCODE_CORRECT_CORE_MACROS_SVH
`define CYCLIC_CODE_ENCODE_CORRECT_CORE_MACROS_SVH

// Same-cycle implication.
`define CCEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ccec_pkg.sv
`default_nettype none

package ccec_pkg;

  localparam int MAX_DEGREE  = 6;
  localparam int MAX_LENGTH  = 63;
  localparam int WORD_W      = 63;
  localparam int REM_W       = MAX_DEGREE;
  localparam int STEP_W      = REM_W + 1;
  localparam int POS_W       = 6;
  localparam int DEG_W       = 3;
  localparam int LEN_W       = 6;
  localparam int CHUNK       = 8;
  localparam int MOD_STAGES  = (WORD_W + CHUNK) / CHUNK;
  localparam int SRCH_STAGES = (MAX_LENGTH + CHUNK - 1) / CHUNK;
  localparam int NSTG        = 1 + MOD_STAGES + SRCH_STAGES;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 72;

  localparam logic [CFG_DATA_W-1:0] GEN_POLY_RST    = 7'd11;
  localparam logic [DEG_W-1:0]      CODE_DEGREE_RST = 3'd3;
  localparam logic [LEN_W-1:0]      CODE_LENGTH_RST = 6'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEN_POLY    = 2'd0,
    CFG_CODE_DEGREE = 2'd1,
    CFG_CODE_LENGTH = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_t;

  // Effective code parameters derived from the configuration registers.
  typedef struct packed {
    logic [DEG_W-1:0]  r;
    logic [LEN_W-1:0]  n;
    logic [LEN_W-1:0]  k;
    logic [STEP_W-1:0] g;
    logic [STEP_W-1:0] top;
  } code_cfg_t;

  // One item in flight.
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
    logic [REM_W-1:0]  synd;
    logic [REM_W-1:0]  pw;
    logic              hit;
    logic [POS_W-1:0]  pos;
  } stage_t;

  // One shift of the division register, reducing by g when the top bit appears.
  function automatic logic [REM_W-1:0] poly_step(input logic [REM_W-1:0] rem,
                                                 input logic b,
                                                 input logic [STEP_W-1:0] g,
                                                 input logic [STEP_W-1:0] top);
    logic [STEP_W-1:0] t;
    t = {rem, b};
    if ((t & top) != '0) begin
      t = t ^ g;
    end
    return t[REM_W-1:0];
  endfunction

  // Feed CHUNK bits, highest first, into the remainder.
  function automatic stage_t mod_chunk(input stage_t st,
                                       input logic [CHUNK-1:0] bits,
                                       input code_cfg_t cc);
    stage_t o;
    o = st;
    for (int b = CHUNK - 1; b >= 0; b--) begin
      o.synd = poly_step(o.synd, bits[b], cc.g, cc.top);
    end
    return o;
  endfunction

  // Compare the syndrome against x^p mod g for CHUNK positions from base.
  function automatic stage_t search_chunk(input stage_t st,
                                          input logic [POS_W-1:0] base,
                                          input code_cfg_t cc);
    stage_t         o;
    logic [POS_W:0] p;
    o = st;
    for (int b = 0; b < CHUNK; b++) begin
      p = {1'b0, base} + (POS_W+1)'(b);
      if (!o.hit && (p < {1'b0, cc.n}) && (o.pw == o.synd) && (o.synd != '0)) begin
        o.hit = 1'b1;
        o.pos = p[POS_W-1:0];
      end
      o.pw = poly_step(o.pw, 1'b0, cc.g, cc.top);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: src/cyclic_code_encode_correct_core.sv
// Cyclic code encoder and single-error corrector with a programmable generator
// g(x) of degree r (up to 6) and codeword length n (up to 63). An encode
// transaction (in_tuser = 0) carries k = n - r information bits and returns the
// systematic codeword x^r*i(x) + (x^r*i(x) mod g); a decode transaction
// (in_tuser = 1) carries n received bits, forms the syndrome, flips the lowest
// bit position p < n with x^p mod g equal to a nonzero syndrome, and returns the
// k information bits with error_found, error_position and uncorrectable.
// A new transaction is taken every clock unless a stalled output has filled the
// pipeline. Each one passes through one input stage, eight remainder stages of
// eight bits each, eight search stages of eight positions each, and the output
// register. Backpressure is absorbed stage by stage, so bubbles close up behind
// a stalled result.
// Configuration writes take effect on the next clock and are to be issued only
// while no transaction is in flight; writes to an index beyond the third
// register are dropped.
`default_nettype none
`include "cyclic_code_encode_correct_core_macros.svh"

module cyclic_code_encode_correct_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [ccec_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [ccec_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input stream
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [ccec_pkg::IN_DATA_W-1:0]    in_tdata,   // [62:0] word_in, [63] zero
  input  wire logic                              in_tuser,   // [0] kind
  // Result stream
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // [62:0] word_out, [63] error_found, [69:64] error_position,
  // [70] uncorrectable, [71] zero
  output      logic [ccec_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import ccec_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] gen_poly_r;
  logic [DEG_W-1:0]      code_degree_r;
  logic [LEN_W-1:0]      code_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_poly_r    <= GEN_POLY_RST;
      code_degree_r <= CODE_DEGREE_RST;
      code_length_r <= CODE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_GEN_POLY:    gen_poly_r    <= cfg_wdata;
        CFG_CODE_DEGREE: code_degree_r <= cfg_wdata[DEG_W-1:0];
        CFG_CODE_LENGTH: code_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective code: saturate r, force the degree bit, drop bits above it.
  // A 6-bit length never exceeds the 63-bit maximum, so n needs no clamp.
  code_cfg_t cc;

  always_comb begin
    cc.r   = (code_degree_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : code_degree_r;
    cc.n   = code_length_r;
    cc.k   = (cc.n > LEN_W'(cc.r)) ? (cc.n - LEN_W'(cc.r)) : '0;
    cc.top = STEP_W'(1) << cc.r;
    cc.g   = (gen_poly_r & (cc.top - STEP_W'(1))) | cc.top;
  end

  logic [WORD_W-1:0] n_mask;
  logic [WORD_W-1:0] k_mask;

  assign n_mask = WORD_W'((64'd1 << cc.n) - 64'd1);
  assign k_mask = WORD_W'((64'd1 << cc.k) - 64'd1);

  // Pipeline: stage 0 prepares the word, then remainder stages, then search
  // stages. Each stage advances when the one after it is empty or moving.
  stage_t            stage_r   [NSTG];
  stage_t            stage_nxt [NSTG];
  logic [NSTG-1:0]   valid_r;
  logic [NSTG:0]     rdy;

  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_word_r;
  logic                  out_err_r;
  logic [POS_W-1:0]      out_pos_r;
  logic                  out_unc_r;

  assign rdy[NSTG] = !out_valid_r || out_tready;
  assign in_tready = rdy[0];

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic prev_valid;

    assign rdy[i] = !valid_r[i] || rdy[i+1];

    if (i == 0) begin : g_in
      logic [IN_DATA_W-1:0] shifted;

      assign prev_valid = in_tvalid;
      // Encode: place the information bits above the check bits.
      // Decode: keep only the n received bits.
      assign shifted = {1'b0, in_tdata[WORD_W-1:0] & k_mask} << cc.r;

      always_comb begin
        stage_nxt[i].kind = kind_t'(in_tuser);
        stage_nxt[i].word = (kind_t'(in_tuser) == KIND_ENCODE) ?
                            shifted[WORD_W-1:0] : (in_tdata[WORD_W-1:0] & n_mask);
        stage_nxt[i].synd = '0;
        stage_nxt[i].pw   = (cc.r != '0) ? REM_W'(1) : '0;
        stage_nxt[i].hit  = 1'b0;
        stage_nxt[i].pos  = '0;
      end
    end else if (i <= MOD_STAGES) begin : g_mod
      localparam int HI = WORD_W - CHUNK * (i - 1);
      logic [WORD_W:0] padded;

      assign prev_valid = valid_r[i-1];
      assign padded     = {1'b0, stage_r[i-1].word};

      // Long division, highest bits first.
      always_comb begin
        stage_nxt[i] = mod_chunk(stage_r[i-1], padded[HI -: CHUNK], cc);
      end
    end else begin : g_srch
      localparam logic [POS_W-1:0] BASE = POS_W'(CHUNK * (i - 1 - MOD_STAGES));

      assign prev_valid = valid_r[i-1];

      // Walk x^p mod g and latch the first matching position.
      always_comb begin
        stage_nxt[i] = search_chunk(stage_r[i-1], BASE, cc);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid_r[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && prev_valid) begin
        stage_r[i] <= stage_nxt[i];
      end
    end
  end

  // Result formatting.
  stage_t            last;
  logic [WORD_W-1:0] fixed_word;
  logic [WORD_W-1:0] out_word_nxt;
  logic              out_err_nxt;
  logic [POS_W-1:0]  out_pos_nxt;
  logic              out_unc_nxt;

  assign last = stage_r[NSTG-1];

  always_comb begin
    fixed_word   = last.word ^ (last.hit ? (WORD_W'(1) << last.pos) : '0);
    out_word_nxt = '0;
    out_err_nxt  = 1'b0;
    out_pos_nxt  = '0;
    out_unc_nxt  = 1'b0;
    if (last.kind == KIND_ENCODE) begin
      // Append the check bits below the information part.
      out_word_nxt = (last.word ^ WORD_W'(last.synd)) & n_mask;
    end else begin
      // Drop the check bits; word was already limited to n bits.
      out_word_nxt = fixed_word >> cc.r;
      out_err_nxt  = (last.synd != '0);
      out_pos_nxt  = last.hit ? last.pos : '0;
      out_unc_nxt  = (last.synd != '0) && !last.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NSTG]) begin
      out_valid_r <= valid_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG] && valid_r[NSTG-1]) begin
      out_word_r <= out_word_nxt;
      out_err_r  <= out_err_nxt;
      out_pos_r  <= out_pos_nxt;
      out_unc_r  <= out_unc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_unc_r, out_pos_r, out_err_r, out_word_r};

  `CCEC_ASSERT_NXT(a_accept_lands, in_tvalid && in_tready, valid_r[0],
                   "accepted transaction did not enter the first stage")

  `CCEC_ASSERT_NXT(a_last_holds, valid_r[NSTG-1] && !rdy[NSTG],
                   valid_r[NSTG-1] && $stable(stage_r[NSTG-1]),
                   "last pipeline stage changed while the output stalled")

  `CCEC_ASSERT_NXT(a_encode_clean,
                   valid_r[NSTG-1] && rdy[NSTG] && (last.kind == KIND_ENCODE),
                   !out_err_r && !out_unc_r && (out_pos_r == '0),
                   "encode result carries error flags")

  `CCEC_ASSERT_IMP(a_unc_has_err, out_valid_r && out_unc_r, out_err_r,
                   "uncorrectable flagged without error_found")

  `CCEC_ASSERT_IMP(a_pos_in_range, out_valid_r && out_err_r && !out_unc_r,
                   out_pos_r < code_length_r,
                   "corrected position lies outside the codeword")

endmodule

`default_nettype wire
